[design/pdgc_pkg.sv]
// Shared types and constants of the Poisson-disk grid check block.
package pdgc_pkg;

   // Fixed field widths.
   localparam int COORD_W   = 18;
   localparam int POINT_W   = 17;
   localparam int SCALE_W   = 16;
   localparam int DIST_W    = 33;
   localparam int GWIDTH_W  = 7;
   localparam int RANGE_W   = 17;
   localparam int STATUS_W  = 2;
   localparam int CELLOUT_W = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 33;

   // Multiplier and cell arithmetic.
   localparam int PROD_W      = 2 * POINT_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int SCALE_SHIFT = 24;
   localparam int CELL_Q_W    = PROD_W - SCALE_SHIFT;

   // Grid store entry: valid bit, first coordinate, second coordinate.
   localparam int ENTRY_W = 1 + 2 * POINT_W;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST_SQ = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SCALE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_Y     = 3'd4;

   // Register reset values.
   localparam logic [DIST_W-1:0]   RST_MIN_DIST_SQ = 33'd42949673;
   localparam logic [SCALE_W-1:0]  RST_CELL_SCALE  = 16'd3620;
   localparam logic [GWIDTH_W-1:0] RST_GRID_WIDTH  = 7'd15;
   localparam logic [RANGE_W-1:0]  RST_RANGE       = 17'd65536;

   // Operation codes.
   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_TEST  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CLOSE    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

   // Operands of the shared multiplier unit.
   typedef struct packed {
      logic [POINT_W-1:0] a0;
      logic [POINT_W-1:0] b0;
      logic [POINT_W-1:0] a1;
      logic [POINT_W-1:0] b1;
   } mul_req_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_RANGE,
      S_CELL,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_CLEAR,
      S_DONE
   } state_type;

endpackage

[design/poisson_disk_grid_check_core.sv]
// Top level of the Poisson-disk background grid check core.
//
// This core keeps a grid of stored 2D points and checks candidate points
// against it. A candidate item (op 1) is first range checked; the result of an
// item outside the limits goes to the output register after the check, once
// that register is free, and the core then returns to idle for the next item. An
// item in range has its grid cell computed by the shared multiplier, then all
// (2*CHECK_SIZE+1)^2 cells of the window around it are read from the grid RAM
// one per cycle and the squared distances are computed by the same
// multiplier in a three-stage pipeline. The point is then either rejected as
// too close or written into its own cell. The window scan through the single
// read port of the grid RAM sets how long a candidate in range takes, with a
// default CHECK_SIZE of 2. A clear item (op 0) runs a clearing pass that
// writes every one of the GRID_SIDE*GRID_SIDE entries (4096 by default), one
// per cycle; its result goes to the output register once the pass is done and
// that register is free, and the core then returns to idle for the next item.
// The same clearing pass runs after reset, and req_ready stays low until it is
// done; register writes are taken at all times. The core works on one item at
// a time, but it takes the next item while the previous result still waits in
// the output register.
module poisson_disk_grid_check_core
   import pdgc_pkg::*;
#(
   parameter int GRID_SIDE  = 64,
   parameter int CHECK_SIZE = 2
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic signed [COORD_W-1:0] req_x_coord,
   input  logic signed [COORD_W-1:0] req_y_coord,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [CELLOUT_W-1:0]  rsp_cell_row,
   output logic [CELLOUT_W-1:0]  rsp_cell_col,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata
);

   // Derived sizes. IW is the width of a cell index, AW of a store address,
   // and OW of a window offset counter.
   localparam int DEPTH   = GRID_SIDE * GRID_SIDE;
   localparam int IW      = $clog2(GRID_SIDE);
   localparam int AW      = $clog2(DEPTH);
   localparam int WIN_MAX = 2 * CHECK_SIZE;
   localparam int OW      = $clog2(WIN_MAX + 1);

   // Configuration registers.
   logic [DIST_W-1:0]   min_dist_sq_ff;
   logic [SCALE_W-1:0]  cell_scale_ff;
   logic [GWIDTH_W-1:0] grid_width_ff;
   logic [RANGE_W-1:0]  range_x_ff;
   logic [RANGE_W-1:0]  range_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_sq_ff <= RST_MIN_DIST_SQ;
         cell_scale_ff  <= RST_CELL_SCALE;
         grid_width_ff  <= RST_GRID_WIDTH;
         range_x_ff     <= RST_RANGE;
         range_y_ff     <= RST_RANGE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_DIST_SQ: min_dist_sq_ff <= csr_wdata[DIST_W-1:0];
            CSR_CELL_SCALE:  cell_scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[GWIDTH_W-1:0];
            CSR_RANGE_X:     range_x_ff     <= csr_wdata[RANGE_W-1:0];
            CSR_RANGE_Y:     range_y_ff     <= csr_wdata[RANGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer and datapath registers.
   state_type state_ff, state_in;

   logic [COORD_W-1:0]  x_ff, x_in;
   logic [COORD_W-1:0]  y_ff, y_in;
   logic [IW-1:0]       row_ff, row_in;
   logic [IW-1:0]       col_ff, col_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [AW-1:0]       sweep_addr_ff, sweep_addr_in;
   logic [OW-1:0]       roff_ff, roff_in;
   logic [OW-1:0]       coff_ff, coff_in;
   logic                drain_ff, drain_in;
   logic                p1_valid_ff, p1_valid_in;
   logic                p2_valid_ff, p2_valid_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CELLOUT_W-1:0] rsp_cell_row_ff, rsp_cell_row_in;
   logic [CELLOUT_W-1:0] rsp_cell_col_ff, rsp_cell_col_in;

   // Grid RAM and multiplier connections.
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   mul_req_type        mul_req;
   logic [PROD_W-1:0]  prod0;
   logic [PROD_W-1:0]  prod1;

   // Candidate coordinates as unsigned points, valid once range checked.
   logic [POINT_W-1:0] px;
   logic [POINT_W-1:0] py;
   logic               out_of_range;

   assign px = x_ff[POINT_W-1:0];
   assign py = y_ff[POINT_W-1:0];

   // A coordinate is out of range when negative or above its limit.
   assign out_of_range = x_ff[COORD_W-1] || y_ff[COORD_W-1] ||
                         (px > range_x_ff) || (py > range_y_ff);

   // Grid width in use, clamped to between one and GRID_SIDE.
   logic [CELL_Q_W-1:0] w_use;
   logic [CELL_Q_W-1:0] gw_ext;

   always_comb begin
      gw_ext = CELL_Q_W'(grid_width_ff);
      if (gw_ext == '0) begin
         w_use = CELL_Q_W'(1);
      end else if (gw_ext > CELL_Q_W'(GRID_SIDE)) begin
         w_use = CELL_Q_W'(GRID_SIDE);
      end else begin
         w_use = gw_ext;
      end
   end

   // Cell index from the scaled coordinate, clamped to the last cell in use.
   logic [CELL_Q_W-1:0] row_q;
   logic [CELL_Q_W-1:0] col_q;
   logic [IW-1:0]       row_cell;
   logic [IW-1:0]       col_cell;

   always_comb begin
      row_q    = prod0[PROD_W-1:SCALE_SHIFT];
      col_q    = prod1[PROD_W-1:SCALE_SHIFT];
      row_cell = (row_q >= w_use) ? IW'(w_use - CELL_Q_W'(1)) : IW'(row_q);
      col_cell = (col_q >= w_use) ? IW'(w_use - CELL_Q_W'(1)) : IW'(col_q);
   end

   // Window position being issued. The offsets run from zero to twice the
   // check size, so the cell is found by subtracting the check size after
   // the add; cells outside the grid in use are left out of the distance check.
   logic [CELL_Q_W-1:0] r_pos;
   logic [CELL_Q_W-1:0] c_pos;
   logic                win_in_bounds;
   logic [IW-1:0]       r_cell;
   logic [IW-1:0]       c_cell;
   logic                win_last;

   always_comb begin
      r_pos = CELL_Q_W'(row_ff) + CELL_Q_W'(roff_ff);
      c_pos = CELL_Q_W'(col_ff) + CELL_Q_W'(coff_ff);
      win_in_bounds = (r_pos >= CELL_Q_W'(CHECK_SIZE)) &&
                      (c_pos >= CELL_Q_W'(CHECK_SIZE)) &&
                      (r_pos < w_use + CELL_Q_W'(CHECK_SIZE)) &&
                      (c_pos < w_use + CELL_Q_W'(CHECK_SIZE));
      r_cell   = IW'(r_pos - CELL_Q_W'(CHECK_SIZE));
      c_cell   = IW'(c_pos - CELL_Q_W'(CHECK_SIZE));
      win_last = (roff_ff == OW'(WIN_MAX)) && (coff_ff == OW'(WIN_MAX));
   end

   assign ram_raddr = AW'(r_cell) * AW'(GRID_SIDE) + AW'(c_cell);

   // Distance pipeline, stage one: read data is back, form the absolute
   // differences for the multiplier.
   logic               rd_valid;
   logic [POINT_W-1:0] rd_x;
   logic [POINT_W-1:0] rd_y;
   logic [POINT_W-1:0] dx;
   logic [POINT_W-1:0] dy;

   always_comb begin
      rd_valid = ram_rdata[ENTRY_W-1];
      rd_x     = ram_rdata[2*POINT_W-1:POINT_W];
      rd_y     = ram_rdata[POINT_W-1:0];
      dx       = (px >= rd_x) ? (px - rd_x) : (rd_x - px);
      dy       = (py >= rd_y) ? (py - rd_y) : (rd_y - py);
   end

   // The multiplier scales the coordinates while the range check runs, and
   // squares the differences during the window scan.
   always_comb begin
      if (state_ff == S_RANGE) begin
         mul_req.a0 = px;
         mul_req.b0 = POINT_W'(cell_scale_ff);
         mul_req.a1 = py;
         mul_req.b1 = POINT_W'(cell_scale_ff);
      end else begin
         mul_req.a0 = dx;
         mul_req.b0 = dx;
         mul_req.a1 = dy;
         mul_req.b1 = dy;
      end
   end

   pdgc_mul_unit u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod0   (prod0),
      .prod1   (prod1)
   );

   // Stage two: the squares are back, sum them and compare. A distance equal
   // to the minimum is allowed.
   logic [SUM_W-1:0] dist_sq;
   logic             too_close;

   assign dist_sq   = SUM_W'(prod0) + SUM_W'(prod1);
   assign too_close = p2_valid_ff && (dist_sq < SUM_W'(min_dist_sq_ff));

   pdgc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic sweep_last;
   logic out_free;

   assign sweep_last = (sweep_addr_ff == AW'(DEPTH - 1));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_TEST) ? S_RANGE : S_CLEAR;
            end
         end
         S_RANGE: begin
            state_in = out_of_range ? S_DONE : S_CELL;
         end
         S_CELL: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (win_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (drain_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
         end
         S_CLEAR: begin
            if (sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Sequencer outputs and datapath updates.
   always_comb begin
      req_ready       = 1'b0;
      ram_we          = 1'b0;
      ram_waddr       = sweep_addr_ff;
      ram_wdata       = '0;
      x_in            = x_ff;
      y_in            = y_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      status_in       = status_ff;
      sweep_addr_in   = '0;
      roff_in         = '0;
      coff_in         = '0;
      drain_in        = 1'b0;
      p1_valid_in     = 1'b0;
      p2_valid_in     = p1_valid_ff && rd_valid;
      hit_in          = hit_ff || too_close;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_cell_row_in = rsp_cell_row_ff;
      rsp_cell_col_in = rsp_cell_col_ff;

      case (state_ff)
         S_INIT: begin
            ram_we        = 1'b1;
            sweep_addr_in = sweep_addr_ff + AW'(1);
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               x_in      = req_x_coord;
               y_in      = req_y_coord;
               row_in    = '0;
               col_in    = '0;
               status_in = (req_op == OP_TEST) ? ST_RANGE : ST_CLEARED;
            end
         end
         S_RANGE: begin
         end
         S_CELL: begin
            row_in = row_cell;
            col_in = col_cell;
            hit_in = 1'b0;
         end
         S_SCAN: begin
            p1_valid_in = win_in_bounds;
            if (coff_ff == OW'(WIN_MAX)) begin
               coff_in = '0;
               roff_in = roff_ff + OW'(1);
            end else begin
               coff_in = coff_ff + OW'(1);
               roff_in = roff_ff;
            end
         end
         S_DRAIN: begin
            drain_in = !drain_ff;
         end
         S_DECIDE: begin
            if (hit_ff) begin
               status_in = ST_CLOSE;
            end else begin
               status_in = ST_ACCEPTED;
               ram_we    = 1'b1;
               ram_waddr = AW'(row_ff) * AW'(GRID_SIDE) + AW'(col_ff);
               ram_wdata = {1'b1, px, py};
            end
         end
         S_CLEAR: begin
            ram_we        = 1'b1;
            sweep_addr_in = sweep_addr_ff + AW'(1);
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_cell_row_in = CELLOUT_W'(row_ff);
               rsp_cell_col_in = CELLOUT_W'(col_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         sweep_addr_ff <= '0;
         roff_ff       <= '0;
         coff_ff       <= '0;
         drain_ff      <= 1'b0;
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         roff_ff       <= roff_in;
         coff_ff       <= coff_in;
         drain_ff      <= drain_in;
         p1_valid_ff   <= p1_valid_in;
         p2_valid_ff   <= p2_valid_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      y_ff            <= y_in;
      row_ff          <= row_in;
      col_ff          <= col_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_cell_row_ff <= rsp_cell_row_in;
      rsp_cell_col_ff <= rsp_cell_col_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_cell_row = rsp_cell_row_ff;
   assign rsp_cell_col = rsp_cell_col_ff;

   // An accepted item always leaves the core busy in the following cycle.
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready
   ) else $error("core ready right after accepting an item");

   // A distance comparison only follows a window cell read back in the cycle before.
   a_pipe_order: assert property (
      @(posedge clock) disable iff (reset)
      p2_valid_ff |-> $past(p1_valid_ff)
   ) else $error("distance stage valid without a read stage before it");

   // A point is only written into the store when no neighbor was too close.
   a_no_insert_on_hit: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && ram_we) |-> !hit_ff
   ) else $error("point stored although a neighbor was too close");

endmodule

[design/pdgc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pdgc_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pdgc_mul_unit.sv]
// Shared pair of 17 by 17 bit multipliers with registered products.
module pdgc_mul_unit
   import pdgc_pkg::*;
(
   input  logic              clock,
   input  mul_req_type       mul_req,
   output logic [PROD_W-1:0] prod0,
   output logic [PROD_W-1:0] prod1
);

   logic [PROD_W-1:0] prod0_ff;
   logic [PROD_W-1:0] prod1_ff;
   logic [PROD_W-1:0] prod0_in;
   logic [PROD_W-1:0] prod1_in;

   always_comb begin
      prod0_in = PROD_W'(mul_req.a0) * PROD_W'(mul_req.b0);
      prod1_in = PROD_W'(mul_req.a1) * PROD_W'(mul_req.b1);
   end

   always_ff @(posedge clock) begin
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
   end

   assign prod0 = prod0_ff;
   assign prod1 = prod1_ff;

endmodule
